>>> hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SMPQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SMPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/smpq_pkg.sv
// constants, types and helpers of the sorted minimum priority queue
`timescale 1ns / 1ps

package smpq_pkg;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = $clog2(DEPTH + 1);

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } smpq_status_t;

    typedef logic signed [VALUE_WIDTH-1:0] smpq_value_t;

    // command broadcast along the cell chain
    typedef struct packed {
        logic        push;
        logic        pop;
        smpq_value_t key;
    } smpq_cmd_t;

    // 32-bit port value to stored width (sign extend or wrap)
    function automatic smpq_value_t to_value(input logic signed [31:0] x);
        logic signed [63:0] w;
        w = 64'(x);
        return w[VALUE_WIDTH-1:0];
    endfunction

    // stored value to 32-bit port value
    function automatic logic [31:0] to_out(input smpq_value_t x);
        logic signed [63:0] w;
        w = 64'(x);
        return w[31:0];
    endfunction

    // count cut to the 5-bit port
    function automatic logic [4:0] to_count(input logic [CNT_W-1:0] c);
        logic [63:0] w;
        w = 64'(c);
        return w[4:0];
    endfunction

endpackage

>>> hdl/smpq_cell.sv
// one cell of the sorted chain: holds one entry, shifts down on insert, up on pop
`timescale 1ns / 1ps

module smpq_cell
    import smpq_pkg::*;
(
    input  logic        clk,
    input  smpq_cmd_t   cmd,
    input  logic        occupied,
    input  logic        upper_lt,
    input  smpq_value_t upper_val,
    input  smpq_value_t lower_val,
    output smpq_value_t val,
    output smpq_value_t val_next,
    output logic        lt
);

    smpq_value_t val_reg;

    // stored entry strictly smaller than the new key stays put
    assign lt  = occupied && (val_reg < cmd.key);
    assign val = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (cmd.pop)
        begin
            val_next = lower_val;
        end
        else if (cmd.push && !lt)
        begin
            if (upper_lt)
            begin
                val_next = cmd.key;
            end
            else
            begin
                val_next = upper_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

>>> hdl/sorted_min_priority_queue.sv
// top level of the sorted minimum priority queue built as a chain of cells
// channel | handshake                  | beat payload
// item    | item_valid / item_ready    | action, value
// result  | result_valid / result_ready| popped_value, smallest_value, entry_count,
//         |                            | is_empty, status
// one item per cycle while item_ready is high: each beat is resolved in the cell chain in the cycle it is accepted
// the result appears the next cycle in the output register
// the combinational path runs through the per-cell signed compare against the broadcast key
// reset clears the count and the output valid; cell contents stay undefined until written
// a stalled result holds item_ready low only while the output register is full
`timescale 1ns / 1ps

module sorted_min_priority_queue
    import smpq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        action,
    input  logic [31:0] value,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [31:0] popped_value,
    output logic [31:0] smallest_value,
    output logic [4:0]  entry_count,
    output logic        is_empty,
    output logic [1:0]  status
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             result_valid_reg, result_valid_next;
    logic [31:0]      popped_reg, popped_next;
    logic [31:0]      smallest_reg, smallest_next;
    smpq_status_t     status_reg, status_next;

    logic        accept;
    logic        full;
    logic        empty;
    smpq_cmd_t   cmd;

    // cell 0 is the top (smallest)
    smpq_value_t cell_val [DEPTH];
    smpq_value_t cell_nxt [DEPTH];
    logic        cell_lt  [DEPTH];

    // output register frees as soon as its beat is taken
    assign item_ready = !result_valid_reg || result_ready;
    assign accept     = item_valid && item_ready;
    assign full       = (count_reg == CNT_W'(DEPTH));
    assign empty      = (count_reg == '0);

    assign cmd.push = accept && (action == ACT_PUSH) && !full;
    assign cmd.pop  = accept && (action == ACT_POP) && !empty;
    assign cmd.key  = to_value(value);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic        up_lt;
            smpq_value_t up_val;
            smpq_value_t low_val;

            if (gi == 0)
            begin : g_top
                // nothing above the top: a non-smaller entry here takes the key
                assign up_lt  = 1'b1;
                assign up_val = '0;
            end
            else
            begin : g_mid
                assign up_lt  = cell_lt[gi-1];
                assign up_val = cell_val[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_bot
                assign low_val = '0;
            end
            else
            begin : g_low
                assign low_val = cell_val[gi+1];
            end

            smpq_cell u_cell (
                .clk       (clk),
                .cmd       (cmd),
                .occupied  (CNT_W'(gi) < count_reg),
                .upper_lt  (up_lt),
                .upper_val (up_val),
                .lower_val (low_val),
                .val       (cell_val[gi]),
                .val_next  (cell_nxt[gi]),
                .lt        (cell_lt[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next        = count_reg;
        result_valid_next = result_valid_reg;
        popped_next       = popped_reg;
        smallest_next     = smallest_reg;
        status_next       = status_reg;

        if (cmd.push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - 1'b1;
        end

        if (accept)
        begin
            result_valid_next = 1'b1;
            popped_next       = cmd.pop ? to_out(cell_val[0]) : '0;
            smallest_next     = (count_next != '0) ? to_out(cell_nxt[0]) : '0;
            if (action == ACT_POP && empty)
            begin
                status_next = ST_UNDERFLOW;
            end
            else if (action == ACT_PUSH && full)
            begin
                status_next = ST_OVERFLOW;
            end
            else
            begin
                status_next = ST_OK;
            end
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload of the result beat, no reset needed
    always_ff @(posedge clk)
    begin
        popped_reg   <= popped_next;
        smallest_reg <= smallest_next;
        status_reg   <= status_next;
    end

    // the count seen by a result is always the one just committed
    logic [CNT_W-1:0] count_out_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            count_out_reg <= count_next;
        end
    end

    assign result_valid   = result_valid_reg;
    assign popped_value   = popped_reg;
    assign smallest_value = smallest_reg;
    assign entry_count    = to_count(count_out_reg);
    assign is_empty       = (count_out_reg == '0);
    assign status         = status_reg;

endmodule

>>> hdl/smpq_checker.sv
// port-level checks of the sorted minimum priority queue, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module smpq_checker
    import smpq_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_ready,
    input logic        action,
    input logic [31:0] value,
    input logic        result_valid,
    input logic        result_ready,
    input logic [31:0] popped_value,
    input logic [31:0] smallest_value,
    input logic [4:0]  entry_count,
    input logic        is_empty,
    input logic [1:0]  status
);

    `SMPQ_ASSERT_IMPLY(a_empty_flag, clk, rst_n, result_valid, is_empty == (entry_count == 5'd0), "empty flag disagrees with count")
    `SMPQ_ASSERT_IMPLY(a_empty_smallest, clk, rst_n, result_valid && is_empty, smallest_value == 32'd0 && status != ST_OVERFLOW, "empty store shows a value or overflow")
    `SMPQ_ASSERT_IMPLY(a_underflow, clk, rst_n, result_valid && status == ST_UNDERFLOW, is_empty && popped_value == 32'd0, "underflow changed state or returned data")
    `SMPQ_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(smallest_value) && $stable(status), "stalled result beat changed")

endmodule

bind sorted_min_priority_queue smpq_checker u_smpq_checker (.*);
